// File: rtl/raqf_pkg.sv
// raqf_pkg: word types, request and status codes, and config constants for
// the result queue with abandon filter. No dependencies.
package raqf_pkg;

  localparam int ID_W     = 32;
  localparam int PAY_W    = 32;
  localparam int LIMIT_W  = 5;
  localparam int FILL_W   = 5;
  localparam int CTR_W    = 32;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  // request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_MARK  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROP_FULL = 2'd1;
  localparam logic [1:0] ST_DROP_ABAN = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // register map
  localparam logic [CFG_AW-1:0] ADDR_QUEUE_LIMIT = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 5'd16;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [ID_W-1:0]  in_request_id;
    logic [PAY_W-1:0] in_payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              replaced_entry;
    logic [ID_W-1:0]   out_request_id;
    logic [PAY_W-1:0]  out_payload;
    logic [FILL_W-1:0] fill_level;
    logic [FILL_W-1:0] abandoned_fill;
    logic [CTR_W-1:0]  push_total;
    logic [CTR_W-1:0]  pop_total;
    logic [CTR_W-1:0]  drop_total;
    logic [CTR_W-1:0]  abandoned_drop_total;
  } out_word_t;

  // scan unit report, valid for one cycle
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

// File: rtl/raqf_ram.sv
// raqf_ram: simple dual-port RAM, one write and one registered read a cycle.
// No dependencies.
module raqf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/raqf_scan.sv
// raqf_scan: shared compare unit, walks the abandoned-id RAM one slot a cycle
// looking for a key. Depends on raqf_pkg; drives the RAM read address.
module raqf_scan #(
  parameter int ABANDON_SLOTS = 16,
  parameter int ACW = 5,
  parameter int AAW = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [raqf_pkg::ID_W-1:0] key,
  input  logic [ACW-1:0]         n,
  output logic [AAW-1:0]         raddr,
  input  logic [raqf_pkg::ID_W-1:0] rdata,
  output raqf_pkg::scan_res_t    res,
  output logic [AAW-1:0]         hit_idx
);
  import raqf_pkg::*;

  logic              active_r, active_nxt;
  logic              pend_r, pend_nxt;
  logic [AAW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [ACW-1:0]    idx_r, idx_nxt;
  logic [ACW-1:0]    n_r, n_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;
  logic              match;
  logic              at_end;

  assign match   = pend_r && (rdata == key_r);
  assign at_end  = (idx_r >= n_r);
  assign raddr   = idx_r[AAW-1:0];
  assign hit_idx = pend_idx_r;

  always_comb begin
    active_nxt   = active_r;
    pend_nxt     = 1'b0;
    pend_idx_nxt = pend_idx_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    key_nxt      = key_r;
    res.done     = 1'b0;
    res.hit      = 1'b0;
    if (start) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
      n_nxt      = n;
      key_nxt    = key;
    end else if (active_r) begin
      if (match || at_end) begin
        // result in the same cycle the last read data comes back
        res.done   = 1'b1;
        res.hit    = match;
        active_nxt = 1'b0;
      end else begin
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r[AAW-1:0];
        idx_nxt      = idx_r + ACW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= pend_nxt;
    end
    pend_idx_r <= pend_idx_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    key_r      <= key_nxt;
  end

endmodule

// File: rtl/result_queue_abandon_filter.sv
// result_queue_abandon_filter: result FIFO with abandoned-id set; uses raqf_pkg,
// raqf_ram and raqf_scan. A pop reads the head; other kinds scan the set for the
// request id first. A clear hit moves the last member into its slot; a push into
// a full queue replaces its oldest abandoned entry, else the push is dropped.
// Throughput: one word at a time, busy after accept through the out_valid cycle.
// Result shown one cycle, no stall. Sync reset: queue and set empty, limit 16.
module result_queue_abandon_filter #(
  parameter int FIFO_DEPTH    = 16,
  parameter int ABANDON_SLOTS = 16,
  parameter int BODY_WIDTH    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  raqf_pkg::in_word_t            in_word,
  // result channel
  output logic                          out_valid,
  output raqf_pkg::out_word_t           out_word,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [raqf_pkg::CFG_AW-1:0]   paddr,
  input  logic [raqf_pkg::CFG_DW-1:0]   pwdata,
  output logic [raqf_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import raqf_pkg::*;

  localparam int FAW  = $clog2(FIFO_DEPTH);
  localparam int FAW1 = FAW + 1;
  localparam int FCW  = $clog2(FIFO_DEPTH + 1);
  localparam int AAW  = (ABANDON_SLOTS > 1) ? $clog2(ABANDON_SLOTS) : 1;
  localparam int ACW  = $clog2(ABANDON_SLOTS + 1);
  localparam int LW   = (FCW > LIMIT_W) ? FCW : LIMIT_W;
  localparam int FWW  = ID_W + BODY_WIDTH;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;  // look up request id in set
  localparam logic [3:0] S_POP   = 4'd2;  // read head
  localparam logic [3:0] S_POPD  = 4'd3;  // head data back
  localparam logic [3:0] S_FRD   = 4'd4;  // read queued entry i
  localparam logic [3:0] S_FKEY  = 4'd5;  // entry id back, launch scan
  localparam logic [3:0] S_FSCAN = 4'd6;  // is entry i abandoned?
  localparam logic [3:0] S_CRD   = 4'd7;  // read last set member
  localparam logic [3:0] S_CWR   = 4'd8;  // move it into cleared slot
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [BODY_WIDTH-1:0] body_r, body_nxt;
  logic [FAW-1:0]        head_r, head_nxt;
  logic [FCW-1:0]        fcount_r, fcount_nxt;
  logic [ACW-1:0]        acount_r, acount_nxt;
  logic [FCW-1:0]        i_r, i_nxt;
  logic [AAW-1:0]        hitidx_r, hitidx_nxt;
  logic [CTR_W-1:0]      push_ctr_r, push_ctr_nxt;
  logic [CTR_W-1:0]      pop_ctr_r, pop_ctr_nxt;
  logic [CTR_W-1:0]      drop_ctr_r, drop_ctr_nxt;
  logic [CTR_W-1:0]      adrop_ctr_r, adrop_ctr_nxt;
  logic [1:0]            res_status_r, res_status_nxt;
  logic                  res_repl_r, res_repl_nxt;
  logic [ID_W-1:0]       res_id_r, res_id_nxt;
  logic [PAY_W-1:0]      res_body_r, res_body_nxt;
  logic [LIMIT_W-1:0]    limit_r;

  // FIFO RAM: {id, body}
  logic                  f_we;
  logic [FAW-1:0]        f_waddr, f_raddr;
  logic [FWW-1:0]        f_wdata, f_rdata;
  // abandoned-id RAM
  logic                  a_we;
  logic [AAW-1:0]        a_waddr, a_raddr, scan_raddr;
  logic [ID_W-1:0]       a_wdata, a_rdata;
  // scan unit
  logic                  scan_start;
  logic [ID_W-1:0]       scan_key;
  scan_res_t             scan_res;
  logic [AAW-1:0]        scan_idx;

  logic                  accept;
  logic [LW-1:0]         lim_q, lim_eff;
  logic                  full;

  // ring slot of offset from head, one compare-subtract
  function automatic logic [FAW-1:0] slot_of(input logic [FAW-1:0] off);
    logic [FAW1-1:0] sum;
    sum = {1'b0, head_r} + {1'b0, off};
    if (sum >= FAW1'(FIFO_DEPTH)) begin
      sum = sum - FAW1'(FIFO_DEPTH);
    end
    return sum[FAW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // effective limit: 0 acts as 1, above depth acts as depth
  assign lim_q   = LW'(limit_r);
  assign lim_eff = (lim_q == '0) ? LW'(1) :
                   (lim_q > LW'(FIFO_DEPTH)) ? LW'(FIFO_DEPTH) : lim_q;
  assign full    = (LW'(fcount_r) >= lim_eff);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_QUEUE_LIMIT) ? CFG_DW'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == ADDR_QUEUE_LIMIT)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  raqf_ram #(.DEPTH(FIFO_DEPTH), .WIDTH(FWW), .AW(FAW)) u_fifo_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  raqf_ram #(.DEPTH(ABANDON_SLOTS), .WIDTH(ID_W), .AW(AAW)) u_aset_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  raqf_scan #(.ABANDON_SLOTS(ABANDON_SLOTS), .ACW(ACW), .AAW(AAW)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scan_start),
    .key     (scan_key),
    .n       (acount_r),
    .raddr   (scan_raddr),
    .rdata   (a_rdata),
    .res     (scan_res),
    .hit_idx (scan_idx)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    id_nxt         = id_r;
    body_nxt       = body_r;
    head_nxt       = head_r;
    fcount_nxt     = fcount_r;
    acount_nxt     = acount_r;
    i_nxt          = i_r;
    hitidx_nxt     = hitidx_r;
    push_ctr_nxt   = push_ctr_r;
    pop_ctr_nxt    = pop_ctr_r;
    drop_ctr_nxt   = drop_ctr_r;
    adrop_ctr_nxt  = adrop_ctr_r;
    res_status_nxt = res_status_r;
    res_repl_nxt   = res_repl_r;
    res_id_nxt     = res_id_r;
    res_body_nxt   = res_body_r;
    f_we           = 1'b0;
    f_waddr        = slot_of(fcount_r[FAW-1:0]);
    f_wdata        = {id_r, body_r};
    f_raddr        = head_r;
    a_we           = 1'b0;
    a_waddr        = acount_r[AAW-1:0];
    a_wdata        = id_r;
    a_raddr        = scan_raddr;
    scan_start     = 1'b0;
    scan_key       = in_word.in_request_id;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt       = in_word.req_type;
          id_nxt         = in_word.in_request_id;
          body_nxt       = BODY_WIDTH'(in_word.in_payload);
          res_status_nxt = ST_OK;
          res_repl_nxt   = 1'b0;
          res_id_nxt     = '0;
          res_body_nxt   = '0;
          if (in_word.req_type == REQ_POP) begin
            state_nxt = S_POP;
          end else begin
            scan_start = 1'b1;
            state_nxt  = S_ASCAN;
          end
        end
      end

      S_POP: begin
        f_raddr   = head_r;
        state_nxt = S_POPD;
      end

      S_POPD: begin
        if (fcount_r == '0) begin
          res_status_nxt = ST_EMPTY;
        end else begin
          res_id_nxt   = f_rdata[FWW-1:BODY_WIDTH];
          res_body_nxt = PAY_W'(f_rdata[BODY_WIDTH-1:0]);
          head_nxt     = (head_r == FAW'(FIFO_DEPTH - 1)) ? '0 : head_r + FAW'(1);
          fcount_nxt   = fcount_r - FCW'(1);
          pop_ctr_nxt  = pop_ctr_r + CTR_W'(1);
        end
        state_nxt = S_EMIT;
      end

      S_ASCAN: begin
        if (scan_res.done) begin
          state_nxt = S_EMIT;
          case (kind_r)
            REQ_PUSH: begin
              if (scan_res.hit) begin
                res_status_nxt = ST_DROP_ABAN;
                adrop_ctr_nxt  = adrop_ctr_r + CTR_W'(1);
              end else if (!full) begin
                f_we         = 1'b1;
                f_waddr      = slot_of(fcount_r[FAW-1:0]);
                fcount_nxt   = fcount_r + FCW'(1);
                push_ctr_nxt = push_ctr_r + CTR_W'(1);
              end else begin
                // full: hunt for the oldest abandoned entry
                i_nxt     = '0;
                state_nxt = S_FRD;
              end
            end
            REQ_MARK: begin
              if (!scan_res.hit && (acount_r < ACW'(ABANDON_SLOTS))) begin
                a_we       = 1'b1;
                a_waddr    = acount_r[AAW-1:0];
                acount_nxt = acount_r + ACW'(1);
              end
            end
            REQ_CLEAR: begin
              if (scan_res.hit) begin
                hitidx_nxt = scan_idx;
                state_nxt  = S_CRD;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end

      S_CRD: begin
        a_raddr   = AAW'(acount_r - ACW'(1));
        state_nxt = S_CWR;
      end

      S_CWR: begin
        a_we       = 1'b1;
        a_waddr    = hitidx_r;
        a_wdata    = a_rdata;
        acount_nxt = acount_r - ACW'(1);
        state_nxt  = S_EMIT;
      end

      S_FRD: begin
        if (i_r >= fcount_r) begin
          res_status_nxt = ST_DROP_FULL;
          drop_ctr_nxt   = drop_ctr_r + CTR_W'(1);
          state_nxt      = S_EMIT;
        end else begin
          f_raddr   = slot_of(i_r[FAW-1:0]);
          state_nxt = S_FKEY;
        end
      end

      S_FKEY: begin
        scan_start = 1'b1;
        scan_key   = f_rdata[FWW-1:BODY_WIDTH];
        state_nxt  = S_FSCAN;
      end

      S_FSCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            f_we          = 1'b1;
            f_waddr       = slot_of(i_r[FAW-1:0]);
            push_ctr_nxt  = push_ctr_r + CTR_W'(1);
            adrop_ctr_nxt = adrop_ctr_r + CTR_W'(1);
            res_repl_nxt  = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            i_nxt     = i_r + FCW'(1);
            state_nxt = S_FRD;
          end
        end
      end

      S_EMIT: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fcount_r    <= '0;
      acount_r    <= '0;
      push_ctr_r  <= '0;
      pop_ctr_r   <= '0;
      drop_ctr_r  <= '0;
      adrop_ctr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fcount_r    <= fcount_nxt;
      acount_r    <= acount_nxt;
      push_ctr_r  <= push_ctr_nxt;
      pop_ctr_r   <= pop_ctr_nxt;
      drop_ctr_r  <= drop_ctr_nxt;
      adrop_ctr_r <= adrop_ctr_nxt;
    end
    kind_r       <= kind_nxt;
    id_r         <= id_nxt;
    body_r       <= body_nxt;
    i_r          <= i_nxt;
    hitidx_r     <= hitidx_nxt;
    res_status_r <= res_status_nxt;
    res_repl_r   <= res_repl_nxt;
    res_id_r     <= res_id_nxt;
    res_body_r   <= res_body_nxt;
  end

  // result word straight from state registers during the emit cycle
  assign out_valid                     = (state_r == S_EMIT);
  assign out_word.status               = res_status_r;
  assign out_word.replaced_entry       = res_repl_r;
  assign out_word.out_request_id       = res_id_r;
  assign out_word.out_payload          = res_body_r;
  assign out_word.fill_level           = FILL_W'(fcount_r);
  assign out_word.abandoned_fill       = FILL_W'(acount_r);
  assign out_word.push_total           = push_ctr_r;
  assign out_word.pop_total            = pop_ctr_r;
  assign out_word.drop_total           = drop_ctr_r;
  assign out_word.abandoned_drop_total = adrop_ctr_r;

endmodule
